// ----- rtl/ef3d_pkg.sv -----
// shared types and constants for the 3-d euler flux block
`default_nettype none
package ef3d_pkg;
  localparam int unsigned QW = 32;
  localparam int unsigned RHO_W = 31;
  localparam int unsigned GAMMA_W = 18;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;
  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    DIR_X = 2'd0,
    DIR_Y = 2'd1,
    DIR_Z = 2'd2
  } dir_e;

  typedef struct packed {
    logic [RHO_W-1:0]       density;
    logic signed [QW-1:0]   mom_x;
    logic signed [QW-1:0]   mom_y;
    logic signed [QW-1:0]   mom_z;
    logic signed [QW-1:0]   energy;
  } state_t;

  // saturate a 64 bit signed value to 32 bits
  function automatic logic signed [QW-1:0] sat64(input logic signed [63:0] v);
    logic signed [QW-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = Q_MAX;
    else if (v < -64'sh0000_0000_8000_0000) r = Q_MIN;
    else r = v[QW-1:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/ef3d_div.sv -----
// pipelined restoring divider: one quotient bit per stage, signed result
`default_nettype none
module ef3d_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire logic signed [31:0]      num_i,
  input  wire logic [30:0]             den_i,
  output logic signed [31:0]           quo_o
);
  localparam int unsigned NW = 32 + FRAC_BITS;  // magnitude of m << frac
  localparam int unsigned RW = 33;

  logic [NW-1:0] num_q [NW+1];
  logic [RW-1:0] rem_q [NW+1];
  logic [NW-1:0] quo_q [NW+1];
  logic [30:0]   den_q [NW+1];
  logic          neg_q [NW+1];

  logic [31:0] mag;
  assign mag = num_i[31] ? (~num_i + 32'd1) : num_i;

  always_comb begin
    num_q[0] = {mag, {FRAC_BITS{1'b0}}};
    rem_q[0] = '0;
    quo_q[0] = '0;
    den_q[0] = den_i;
    neg_q[0] = num_i[31];
  end

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [RW-1:0] sh, df;
    assign sh = {rem_q[s][RW-2:0], num_q[s][NW-1-s]};
    assign df = sh - {2'b00, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        rem_q[s+1] <= df[RW-1] ? sh : df;
        quo_q[s+1] <= {quo_q[s][NW-2:0], ~df[RW-1]};
      end
    end
  end

  logic signed [63:0] q64;
  always_comb begin
    q64 = $signed({{(64-NW){1'b0}}, quo_q[NW]});
    if (neg_q[NW]) q64 = -q64;
    quo_o = ef3d_pkg::sat64(q64);
  end
endmodule
`default_nettype wire

// ----- rtl/euler_flux_3d.sv -----
// top level: 3-d compressible euler flux, one point in, three direction results out
//
//  channel   dir  fields
//  s_axis    in   tdata {total_energy, mom_z, mom_y, mom_x, density(31)}; 160 bits
//  m_axis    out  tdata {energy, fmz, fmy, fmx, mass}; tuser {bad_density, direction}; tlast
//  cfg       in   cfg_we_i / cfg_wdata_i: gamma (18 bits)
//
// the output emits one direction per cycle while m_axis_tready_i is high; the next point
// is taken from the pipe in the cycle the current z result is accepted. a point passes
// the bit-per-stage divider (32+FRAC_BITS stages), then six multiply / add stages; y
// and z follow x one per cycle while m_axis_tready_i is high.
// the whole pipe advances only when its last stage is empty or handed to the output
// serializer, so a stall freezes every stage; nothing is lost or repeated.
// reset clears the valid bits and presets gamma; data registers carry no reset.
`default_nettype none
module euler_flux_3d #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [17:0]        cfg_wdata_i,
  input  wire                s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire  [159:0]       s_axis_tdata_i,  // density[30:0], pad, mom_x, mom_y, mom_z, energy
  output logic               m_axis_tvalid_o,
  input  wire                m_axis_tready_i,
  output logic [159:0]       m_axis_tdata_o,  // mass, fmx, fmy, fmz, energy flux
  output logic [2:0]         m_axis_tuser_o,  // direction[1:0], bad_density
  output logic               m_axis_tlast_o
);
  localparam int unsigned DL = 32 + FRAC_BITS;  // divider depth
  localparam int unsigned NV = DL + 6;

  // gamma register
  logic [17:0] gamma_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gamma_q <= ef3d_pkg::GAMMA_RESET;
    else if (cfg_we_i) gamma_q <= cfg_wdata_i;
  end

  // input unpack; density at bit 0, 32 bit slots follow
  ef3d_pkg::state_t in_s;
  assign in_s.density = s_axis_tdata_i[30:0];
  assign in_s.mom_x   = s_axis_tdata_i[63:32];
  assign in_s.mom_y   = s_axis_tdata_i[95:64];
  assign in_s.mom_z   = s_axis_tdata_i[127:96];
  assign in_s.energy  = s_axis_tdata_i[159:128];

  // output serializer: holds one point, emits x,y,z
  logic        ov_q;
  logic [1:0]  dir_q;
  logic        adv;   // pipe step
  logic        v_q [NV+1];
  logic        take;
  assign take = v_q[NV] && (!ov_q || (m_axis_tready_i && dir_q == ef3d_pkg::DIR_Z));
  assign adv  = !v_q[NV] || take;
  assign s_axis_tready_o = adv;

  always_comb v_q[0] = s_axis_tvalid_i;
  for (genvar i = 0; i < NV; i++) begin : g_v
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (adv) v_q[i+1] <= v_q[i];
    end
  end

  // state travels beside the divider
  ef3d_pkg::state_t st_q [DL+1];
  always_comb st_q[0] = in_s;
  for (genvar i = 0; i < DL; i++) begin : g_st
    always_ff @(posedge clk_i) if (adv) st_q[i+1] <= st_q[i];
  end

  logic signed [31:0] ux, uy, uz;
  ef3d_div #(.FRAC_BITS(FRAC_BITS)) u_dx (.clk_i, .en_i(adv), .num_i(in_s.mom_x),
    .den_i(in_s.density), .quo_o(ux));
  ef3d_div #(.FRAC_BITS(FRAC_BITS)) u_dy (.clk_i, .en_i(adv), .num_i(in_s.mom_y),
    .den_i(in_s.density), .quo_o(uy));
  ef3d_div #(.FRAC_BITS(FRAC_BITS)) u_dz (.clk_i, .en_i(adv), .num_i(in_s.mom_z),
    .den_i(in_s.density), .quo_o(uz));

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] pr;
    pr = a * b;
    return ef3d_pkg::sat64(pr >>> FRAC_BITS);
  endfunction

  ef3d_pkg::state_t s1_q, s2_q, s3_q, s4_q, s5_q;
  logic signed [31:0] u1_q [3], u2_q [3], u3_q [3], u4_q [3], u5_q [3];
  // stage 1: m*u for all nine pairs
  logic signed [31:0] mu1_q [3][3];  // [i][d] = qmul(m_i, u_d)
  logic signed [31:0] mu2_q [3][3], mu3_q [3][3], mu4_q [3][3];
  logic signed [31:0] ke_q, emk_q, p_q, ep_q, fe_q [3];
  logic signed [31:0] p4_q;
  logic signed [31:0] fmo_q [3][3];
  logic [17:0] g1_q, g2_q;

  logic signed [31:0] m0 [3];
  assign m0[0] = st_q[DL].mom_x;
  assign m0[1] = st_q[DL].mom_y;
  assign m0[2] = st_q[DL].mom_z;
  logic signed [31:0] uu [3];
  assign uu[0] = ux;
  assign uu[1] = uy;
  assign uu[2] = uz;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      s1_q <= st_q[DL];
      g1_q <= gamma_q;
      for (int i = 0; i < 3; i++) begin
        u1_q[i] <= uu[i];
        for (int d = 0; d < 3; d++) mu1_q[i][d] <= qmul(m0[i], uu[d]);
      end
      // stage 2: kinetic energy
      s2_q <= s1_q;
      g2_q <= g1_q;
      u2_q <= u1_q;
      mu2_q <= mu1_q;
      ke_q <= ef3d_pkg::sat64((64'(mu1_q[0][0]) + 64'(mu1_q[1][1]) + 64'(mu1_q[2][2])) >>> 1);
      // stage 3: e - ke and gamma - 1
      s3_q <= s2_q;
      u3_q <= u2_q;
      mu3_q <= mu2_q;
      emk_q <= ef3d_pkg::sat64(64'(s2_q.energy) - 64'(ke_q));
      p_q <= $signed({14'd0, g2_q}) - $signed(32'(1) <<< FRAC_BITS);
      // stage 4: pressure
      s4_q <= s3_q;
      u4_q <= u3_q;
      mu4_q <= mu3_q;
      p4_q <= qmul(p_q, emk_q);
      // stage 5: e + p and diagonal
      s5_q <= s4_q;
      u5_q <= u4_q;
      ep_q <= ef3d_pkg::sat64(64'(s4_q.energy) + 64'(p4_q));
      for (int i = 0; i < 3; i++)
        for (int d = 0; d < 3; d++)
          fmo_q[i][d] <= (i == d) ? ef3d_pkg::sat64(64'(mu4_q[i][d]) + 64'(p4_q))
                                  : mu4_q[i][d];
    end
  end

  // stage 6: energy flux (last pipe stage)
  ef3d_pkg::state_t s6_q;
  logic signed [31:0] fm6_q [3][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_q <= s5_q;
      fm6_q <= fmo_q;
      for (int d = 0; d < 3; d++) fe_q[d] <= qmul(u5_q[d], ep_q);
    end
  end

  // output serializer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      dir_q <= ef3d_pkg::DIR_X;
    end else if (take) begin
      ov_q  <= 1'b1;
      dir_q <= ef3d_pkg::DIR_X;
    end else if (ov_q && m_axis_tready_i) begin
      if (dir_q == ef3d_pkg::DIR_Z) ov_q <= 1'b0;
      else dir_q <= dir_q + 2'd1;
    end
  end

  ef3d_pkg::state_t so_q;
  logic signed [31:0] fmh_q [3][3], feh_q [3];
  always_ff @(posedge clk_i) begin
    if (take) begin
      so_q  <= s6_q;
      fmh_q <= fm6_q;
      feh_q <= fe_q;
    end
  end

  logic bad;
  logic signed [31:0] mass;
  assign bad = (so_q.density == '0);
  always_comb begin
    unique case (dir_q)
      ef3d_pkg::DIR_X: mass = so_q.mom_x;
      ef3d_pkg::DIR_Y: mass = so_q.mom_y;
      default:         mass = so_q.mom_z;
    endcase
  end
  logic [1:0] di;
  assign di = (dir_q > ef3d_pkg::DIR_Z) ? ef3d_pkg::DIR_Z : dir_q;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tlast_o  = (dir_q == ef3d_pkg::DIR_Z);
  assign m_axis_tuser_o  = {bad, dir_q};
  assign m_axis_tdata_o  = bad ? '0 : {feh_q[di], fmh_q[2][di], fmh_q[1][di], fmh_q[0][di], mass};

  // assertions
  a_last_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (dir_q == ef3d_pkg::DIR_Z))) else $error("last");
  a_dir_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && m_axis_tready_i && dir_q == ef3d_pkg::DIR_X && !take) |=> dir_q == ef3d_pkg::DIR_Y)
    else $error("dir");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NV] && !adv) |=> v_q[NV]) else $error("hold");
endmodule
`default_nettype wire
